### src/gbu_pkg.sv
// Shared types, constants and helpers for the GB2312 to UTF-8 transcoder.
// No dependencies; gbu_front, gbu_queue, gbu_back and the top level import this package.
package gbu_pkg;

    localparam int unsigned DEF_ROWS    = 94;
    localparam int unsigned DEF_COLS    = 94;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned CP_W        = 16;

    localparam logic [7:0] GB_FIRST  = 8'hA1;
    localparam logic [7:0] GB_LAST   = 8'hFE;
    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [15:0] TWO_BYTE_MAX = 16'h07FF;
    localparam logic [7:0] LEAD2_MARK = 8'hC0;
    localparam logic [7:0] LEAD3_MARK = 8'hE0;
    localparam logic [7:0] CONT_MARK  = 8'h80;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_RANGE    = 2'd1;
    localparam logic [1:0] ERR_DANGLING = 2'd2;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_CP   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        STEP_0 = 3'b001,
        STEP_1 = 3'b010,
        STEP_2 = 3'b100
    } step_t;

    typedef struct packed {
        op_t              op;
        logic [CP_W-1:0]  value;
        logic [1:0]       err;
    } entry_t;

    function automatic logic [7:0] gb_offset(logic [7:0] b);
        return b - GB_FIRST;
    endfunction

    function automatic logic gb_ok(logic [7:0] b, int unsigned limit);
        logic [7:0] idx;
        idx = b - GB_FIRST;
        return (b >= GB_FIRST) && (b <= GB_LAST) && ({24'b0, idx} < limit);
    endfunction

endpackage

### src/gbu_in_if.sv
// Input channel of the transcoder: table loads and GB2312 text bytes.
// Depends on nothing.
interface gbu_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;
    logic [6:0] table_row;
    logic [6:0] table_col;
    logic [15:0] code_point;
    logic       end_of_text;

    modport source (output valid, kind, data_byte, table_row, table_col, code_point,
                    end_of_text, input ready);
    modport sink   (input valid, kind, data_byte, table_row, table_col, code_point,
                    end_of_text, output ready);
endinterface

### src/gbu_out_if.sv
// Output channel of the transcoder: one UTF-8 byte or error result per transaction.
// Depends on nothing.
interface gbu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] error_kind;

    modport source (output valid, out_byte, last, error_kind, input ready);
    modport sink   (input valid, out_byte, last, error_kind, output ready);
endinterface

### src/gbu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module gbu_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/gbu_front.sv
// Front end: accepts input transactions, writes table loads, tracks the lead byte,
// classifies text bytes and issues table reads. Uses gbu_pkg and gbu_in_if.
module gbu_front
    import gbu_pkg::*;
#(
    parameter int unsigned ROWS = DEF_ROWS,
    parameter int unsigned COLS = DEF_COLS,
    localparam int unsigned ADDR_W = (ROWS * COLS > 1) ? $clog2(ROWS * COLS) : 1
) (
    input  logic              clk,
    input  logic              rst_n,
    gbu_in_if.sink            text_in,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_waddr,
    output logic [CP_W-1:0]   ram_wdata,
    output logic              ram_re,
    output logic [ADDR_W-1:0] ram_raddr,
    input  logic [CP_W-1:0]   ram_rdata,
    output logic              push,
    output entry_t            push_entry,
    input  logic              q_full
);

    logic       lead_pending_reg, lead_pending_next;
    logic [6:0] lead_row_reg, lead_row_next;
    logic       s1_valid_reg, s1_valid_next;
    op_t        s1_op_reg, s1_op_next;
    logic [7:0] s1_byte_reg, s1_byte_next;
    logic [1:0] s1_err_reg, s1_err_next;
    logic       s1_load;
    logic       accept;
    logic [7:0] offs;
    logic       row_ok, col_ok;

    assign push           = s1_valid_reg && !q_full;
    assign text_in.ready  = !s1_valid_reg || !q_full;
    assign accept         = text_in.valid && text_in.ready;
    assign offs           = gb_offset(text_in.data_byte);
    assign row_ok         = {1'b0, text_in.table_row} < 8'(ROWS);
    assign col_ok         = {1'b0, text_in.table_col} < 8'(COLS);

    assign ram_wdata = text_in.code_point;
    assign ram_waddr = ADDR_W'({7'b0, text_in.table_row} * 14'(COLS)
                               + {7'b0, text_in.table_col});
    assign ram_raddr = ADDR_W'({7'b0, lead_row_reg} * 14'(COLS) + {7'b0, offs[6:0]});

    always_comb
    begin
        lead_pending_next = lead_pending_reg;
        lead_row_next     = lead_row_reg;
        s1_valid_next     = s1_valid_reg && !push;
        s1_load           = 1'b0;
        s1_op_next        = OP_BYTE;
        s1_byte_next      = 8'h00;
        s1_err_next       = ERR_OK;
        ram_we            = 1'b0;
        ram_re            = 1'b0;
        if (accept)
        begin
            if (text_in.kind == KIND_LOAD)
            begin
                ram_we = row_ok && col_ok;
            end
            else if (lead_pending_reg)
            begin
                lead_pending_next = 1'b0;
                s1_load           = 1'b1;
                if (gb_ok(text_in.data_byte, COLS))
                begin
                    s1_op_next = OP_CP;
                    ram_re     = 1'b1;
                end
                else
                begin
                    s1_err_next = ERR_RANGE;
                end
            end
            else if (text_in.data_byte <= ASCII_MAX)
            begin
                s1_load      = 1'b1;
                s1_byte_next = text_in.data_byte;
            end
            else if (gb_ok(text_in.data_byte, ROWS))
            begin
                if (text_in.end_of_text)
                begin
                    s1_load     = 1'b1;
                    s1_err_next = ERR_DANGLING;
                end
                else
                begin
                    lead_pending_next = 1'b1;
                    lead_row_next     = offs[6:0];
                end
            end
            else
            begin
                s1_load     = 1'b1;
                s1_err_next = ERR_RANGE;
            end
        end
        if (s1_load)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_pending_reg <= 1'b0;
            lead_row_reg     <= 7'd0;
            s1_valid_reg     <= 1'b0;
        end
        else
        begin
            lead_pending_reg <= lead_pending_next;
            lead_row_reg     <= lead_row_next;
            s1_valid_reg     <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_op_reg   <= s1_op_next;
            s1_byte_reg <= s1_byte_next;
            s1_err_reg  <= s1_err_next;
        end
    end

    always_comb
    begin
        push_entry.op  = s1_op_reg;
        push_entry.err = s1_err_reg;
        case (s1_op_reg)
            OP_CP:   push_entry.value = ram_rdata;
            default: push_entry.value = {8'h00, s1_byte_reg};
        endcase
    end

endmodule

### src/gbu_queue.sv
// Short register queue between front and back end.
// Uses gbu_pkg for the entry type.
module gbu_queue
    import gbu_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH,
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CW = $clog2(DEPTH + 1)
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    input  logic   pop,
    output entry_t head,
    output logic   empty
);

    entry_t         slots [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full    = count_reg == CW'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### src/gbu_back.sv
// Back end: expands queued entries into UTF-8 bytes, one output transaction per cycle while utf8_out.ready is high.
// Uses gbu_pkg and gbu_out_if.
module gbu_back
    import gbu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  entry_t    head,
    input  logic      empty,
    output logic      pop,
    gbu_out_if.source utf8_out
);

    step_t      step_reg, step_next;
    logic       ov_reg, ov_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic [1:0] err_reg, err_next;
    logic       load;
    logic       three;
    logic [15:0] v;

    assign v     = head.value;
    assign three = v > TWO_BYTE_MAX;
    assign load  = !empty && (!ov_reg || utf8_out.ready);

    always_comb
    begin
        byte_next = {4'h0, v[15:12]} | LEAD3_MARK;
        last_next = 1'b0;
        err_next  = head.err;
        case (head.op)
            OP_CP:
            begin
                unique case (step_reg)
                    STEP_0:
                    begin
                        byte_next = three ? ({4'h0, v[15:12]} | LEAD3_MARK)
                                          : ({3'b000, v[10:6]} | LEAD2_MARK);
                    end
                    STEP_1:
                    begin
                        byte_next = three ? ({2'b00, v[11:6]} | CONT_MARK)
                                          : ({2'b00, v[5:0]} | CONT_MARK);
                        last_next = !three;
                    end
                    STEP_2:
                    begin
                        byte_next = {2'b00, v[5:0]} | CONT_MARK;
                        last_next = 1'b1;
                    end
                    default:
                    begin
                        byte_next = 8'h00;
                        last_next = 1'b1;
                    end
                endcase
            end
            default:
            begin
                byte_next = v[7:0];
                last_next = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        pop       = load && last_next;
        step_next = step_reg;
        ov_next   = ov_reg && !utf8_out.ready;
        if (load)
        begin
            ov_next = 1'b1;
            if (last_next)
            begin
                step_next = STEP_0;
            end
            else
            begin
                unique case (step_reg)
                    STEP_0:  step_next = STEP_1;
                    STEP_1:  step_next = STEP_2;
                    default: step_next = STEP_0;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            ov_reg   <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            last_reg <= last_next;
            err_reg  <= err_next;
        end
    end

    assign utf8_out.valid      = ov_reg;
    assign utf8_out.out_byte   = byte_reg;
    assign utf8_out.last       = last_reg;
    assign utf8_out.error_kind = err_reg;

endmodule

### src/gb2312_to_utf8_transcoder_top.sv
// Top level of the GB2312 to UTF-8 transcoder.
// Depends on gbu_pkg, gbu_in_if, gbu_out_if, gbu_ram, gbu_front, gbu_queue, gbu_back.
//
// Usage:
//   text_in carries one transaction per item: kind 0 writes code_point into the
//   table at (table_row, table_col), kind 1 delivers one GB2312 text byte.
//   utf8_out carries one UTF-8 byte per transaction; last marks the final byte
//   of an input, error_kind flags a bad byte or a dangling lead byte.
//   Load all table entries that the text uses before sending the text.
// Path: a text byte passes the front stage register and the queue before it
//   reaches the output register; a table load gives no output.
// Throughput: one input transaction per cycle on text_in while text_in.ready is
//   high; utf8_out gives one byte per cycle while utf8_out.ready is high, and a
//   character (2 inputs) gives two bytes for a two-byte code point and three
//   for a three-byte one, all through the single output register.
// Reset: clears the held lead byte, the queue and the output register; the
//   table holds no valid data until loaded, and no clearing pass is run.
// Stall: when utf8_out.ready is low the output holds, the queue fills, and
//   text_in.ready drops once the front stage cannot move into the queue.
module gb2312_to_utf8_transcoder_top
    import gbu_pkg::*;
#(
    parameter int unsigned ROWS = DEF_ROWS,
    parameter int unsigned COLS = DEF_COLS
) (
    input  logic      clk,
    input  logic      rst_n,
    gbu_in_if.sink    text_in,
    gbu_out_if.source utf8_out
);

    localparam int unsigned DEPTH  = ROWS * COLS;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CP_W-1:0]   ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CP_W-1:0]   ram_rdata;
    logic              push;
    entry_t            push_entry;
    logic              q_full;
    logic              pop;
    entry_t            head;
    logic              empty;

    gbu_ram #(
        .WIDTH (CP_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    gbu_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_in),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    gbu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .head       (head),
        .empty      (empty)
    );

    gbu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .utf8_out (utf8_out)
    );

endmodule
